@@ src/isl_pkg.sv @@
`timescale 1ns / 1ps
// isl_pkg: types and constants shared by the indexed shift list.
// No dependencies.
package isl_pkg;

  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_PUSH   = 3'd2,
    OP_POP    = 3'd3,
    OP_REMOVE = 3'd4,
    OP_READ   = 3'd5
  } isl_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_PUT,
    ST_DOWN,
    ST_RDW
  } isl_state_t;

  typedef struct packed {
    logic vld;
    logic err;
  } isl_res_t;

endpackage

@@ src/isl_ram.sv @@
`timescale 1ns / 1ps
// isl_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module isl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/isl_seq.sv @@
`timescale 1ns / 1ps
// isl_seq: operation decode, fill count and the read-modify-write shift sweep
// over the entry memory. Depends on isl_pkg.
module isl_seq #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    opcode,
  input  logic [isl_pkg::POS_W-1:0]     position,
  input  logic [WORD_WIDTH-1:0]         word,
  output isl_pkg::isl_res_t             res,
  output logic [WORD_WIDTH-1:0]         res_data,
  output logic [$clog2(CAPACITY+1)-1:0] res_count,
  output logic                          rd_en,
  output logic [$clog2(CAPACITY)-1:0]   rd_addr,
  input  logic [WORD_WIDTH-1:0]         rd_data,
  output logic                          wr_en,
  output logic [$clog2(CAPACITY)-1:0]   wr_addr,
  output logic [WORD_WIDTH-1:0]         wr_data
);
  import isl_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

  isl_state_t state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic [AW-1:0]         prev_r, prev_nxt;
  logic [AW-1:0]         stop_r, stop_nxt;
  logic                  more_r, more_nxt;
  logic                  first_r, first_nxt;
  logic [WORD_WIDTH-1:0] word_r, word_nxt;
  logic [WORD_WIDTH-1:0] data_r, data_nxt;

  logic [CMP_W-1:0] pos_ext, cnt_ext, ipos, rpos, rpos_p1;
  logic [CW-1:0]    cnt_m1, cnt_m2;
  logic             full, null_w;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(cnt_r);
  assign cnt_m1  = cnt_r - CW'(1);
  assign cnt_m2  = cnt_r - CW'(2);
  assign full    = (cnt_r == CW'(CAPACITY));
  assign null_w  = (word == '0);
  assign busy    = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    prev_r  <= prev_nxt;
    stop_r  <= stop_nxt;
    more_r  <= more_nxt;
    first_r <= first_nxt;
    word_r  <= word_nxt;
    data_r  <= data_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    prev_nxt  = prev_r;
    stop_nxt  = stop_r;
    more_nxt  = more_r;
    first_nxt = first_r;
    word_nxt  = word_r;
    data_nxt  = data_r;
    ipos      = '0;
    rpos      = '0;
    rpos_p1   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    res       = '0;
    res_data  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          word_nxt = word;
          unique case (isl_op_t'(opcode)) inside
            OP_INSERT, OP_APPEND, OP_PUSH: begin
              if (isl_op_t'(opcode) == OP_APPEND) begin
                ipos = cnt_ext;
              end else if (isl_op_t'(opcode) == OP_PUSH) begin
                ipos = '0;
              end else begin
                ipos = pos_ext;
              end
              if (null_w || full || (ipos > cnt_ext)) begin
                res = '{vld: 1'b1, err: 1'b1};
              end else if (ipos == cnt_ext) begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                wr_data = word;
                cnt_nxt = cnt_r + CW'(1);
                res     = '{vld: 1'b1, err: 1'b0};
              end else begin
                rd_en     = 1'b1;
                rd_addr   = cnt_m1[AW-1:0];
                prev_nxt  = cnt_m1[AW-1:0];
                addr_nxt  = cnt_m2[AW-1:0];
                more_nxt  = (CMP_W'(cnt_m1) != ipos);
                stop_nxt  = ipos[AW-1:0];
                state_nxt = ST_UP;
              end
            end
            OP_POP, OP_REMOVE: begin
              rpos    = (isl_op_t'(opcode) == OP_POP) ? '0 : pos_ext;
              rpos_p1 = rpos + CMP_W'(1);
              if (rpos >= cnt_ext) begin
                res = '{vld: 1'b1, err: 1'b1};
              end else begin
                rd_en     = 1'b1;
                rd_addr   = rpos[AW-1:0];
                prev_nxt  = rpos[AW-1:0];
                addr_nxt  = rpos_p1[AW-1:0];
                more_nxt  = (rpos_p1 < cnt_ext);
                first_nxt = 1'b1;
                state_nxt = ST_DOWN;
              end
            end
            OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                res = '{vld: 1'b1, err: 1'b1};
              end else begin
                rd_en     = 1'b1;
                rd_addr   = pos_ext[AW-1:0];
                state_nxt = ST_RDW;
              end
            end
            default: begin
              res = '{vld: 1'b1, err: 1'b1};
            end
          endcase
        end
      end
      ST_UP: begin
        wr_en   = 1'b1;
        wr_addr = prev_r + AW'(1);
        wr_data = rd_data;
        if (more_r) begin
          rd_en    = 1'b1;
          rd_addr  = addr_r;
          prev_nxt = addr_r;
          addr_nxt = addr_r - AW'(1);
          more_nxt = (addr_r != stop_r);
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = stop_r;
        wr_data   = word_r;
        cnt_nxt   = cnt_r + CW'(1);
        res       = '{vld: 1'b1, err: 1'b0};
        state_nxt = ST_IDLE;
      end
      ST_DOWN: begin
        first_nxt = 1'b0;
        if (first_r) begin
          data_nxt = rd_data;
        end else begin
          wr_en   = 1'b1;
          wr_addr = prev_r - AW'(1);
          wr_data = rd_data;
        end
        if (more_r) begin
          rd_en    = 1'b1;
          rd_addr  = addr_r;
          prev_nxt = addr_r;
          addr_nxt = addr_r + AW'(1);
          more_nxt = ((CW'(addr_r) + CW'(1)) < cnt_r);
        end else begin
          res       = '{vld: 1'b1, err: 1'b0};
          res_data  = first_r ? rd_data : data_r;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_RDW: begin
        res       = '{vld: 1'b1, err: 1'b0};
        res_data  = rd_data;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_count = cnt_nxt;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |=> state_r == ST_IDLE)
    else $error("result not followed by idle");

  a_rd_wr_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> rd_addr != wr_addr)
    else $error("read and write to the same entry in one cycle");

  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && res.err) |-> (!wr_en && cnt_nxt == cnt_r))
    else $error("error item modified the list");

endmodule

@@ src/indexed_shift_list.sv @@
`timescale 1ns / 1ps
// indexed_shift_list: bounded ordered word list held in one synchronous RAM.
// Errors and inserts at the tail complete from idle; a read goes through the registered RAM read port.
// Insert before the tail shifts entries up, then writes the word; pop/remove shift entries down.
// busy stays high through the shift sweep, which moves one RAM entry per cycle.
// Results strobe for one cycle, cannot be stalled; the next item is taken as a result shows.
// Synchronous active-low reset empties the list; entry contents are not cleared.
module indexed_shift_list #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_opcode,
  input  logic [isl_pkg::POS_W-1:0]   in_position,
  input  logic [isl_pkg::VAL_W-1:0]   in_value,
  output logic                        out_strobe,
  output logic                        out_status,
  output logic [isl_pkg::VAL_W-1:0]   out_data_out,
  output logic [isl_pkg::COUNT_W-1:0] out_count
);
  import isl_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CE_W = (CW > COUNT_W) ? CW : COUNT_W;

  logic [63:0]           val_ext, data_ext;
  logic [WORD_WIDTH-1:0] in_word, res_data;
  logic [CE_W-1:0]       count_ext;
  logic [CW-1:0]         res_count;
  isl_res_t              res;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [WORD_WIDTH-1:0] rd_data, wr_data;

  logic               out_strobe_r;
  logic               out_status_r;
  logic [VAL_W-1:0]   out_data_r;
  logic [COUNT_W-1:0] out_count_r;

  assign val_ext   = 64'(in_value);
  assign in_word   = val_ext[WORD_WIDTH-1:0];
  assign data_ext  = 64'(res_data);
  assign count_ext = CE_W'(res_count);

  isl_seq #(
    .CAPACITY  (CAPACITY),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .opcode   (in_opcode),
    .position (in_position),
    .word     (in_word),
    .res      (res),
    .res_data (res_data),
    .res_count(res_count),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  isl_ram #(
    .WIDTH(WORD_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      out_status_r <= res.err;
      out_data_r   <= data_ext[VAL_W-1:0];
      out_count_r  <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_count    = out_count_r;

endmodule
